// ===== design/acmc_pkg.sv =====
// Shared types and constants for the alarm curtain motor controller.
// No dependencies; imported by acmc_step and alarm_curtain_motor_controller.
`default_nettype none

package acmc_pkg;

    // Operation codes carried in the operation field of an input word.
    localparam logic [2:0] OP_TICK      = 3'd0;
    localparam logic [2:0] OP_MAN_UP    = 3'd1;
    localparam logic [2:0] OP_MAN_DOWN  = 3'd2;
    localparam logic [2:0] OP_SET_UP    = 3'd3;
    localparam logic [2:0] OP_SET_DOWN  = 3'd4;
    localparam logic [2:0] OP_MIDNIGHT  = 3'd5;
    localparam logic [2:0] OP_CUR_EDGE  = 3'd6;

    // Move modes, also the motor drive code.
    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_UP   = 2'd1;
    localparam logic [1:0] MODE_DOWN = 2'd2;

    // Outcome codes of a finished move.
    localparam logic [2:0] OUT_NONE    = 3'd0;
    localparam logic [2:0] OUT_END     = 3'd1;
    localparam logic [2:0] OUT_TIMEOUT = 3'd2;
    localparam logic [2:0] OUT_STALL   = 3'd3;
    localparam logic [2:0] OUT_HALTED  = 3'd4;

    // Alarm fired codes.
    localparam logic [1:0] FIRED_NONE = 2'd0;
    localparam logic [1:0] FIRED_UP   = 2'd1;
    localparam logic [1:0] FIRED_DOWN = 2'd2;

    // Register indexes on the configuration port.
    localparam logic CFG_MOVE_TIMEOUT = 1'b0;
    localparam logic CFG_EDGE_LIMIT   = 1'b1;

    localparam int TIME_W    = 27;
    localparam int ELAPSED_W = 17;
    localparam int TIMEOUT_W = 16;
    localparam int EDGE_W    = 4;

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX       = '1;
    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET     = 16'd60000;
    localparam logic [EDGE_W-1:0]    EDGE_LIMIT_RESET  = 4'd5;

    typedef struct packed {
        logic [2:0]        operation;
        logic [TIME_W-1:0] time_of_day_ms;
        logic [TIME_W-1:0] alarm_ms;
        logic              ceiling_detected;
        logic              floor_detected;
        logic              motor_halted;
    } acmc_item_t;

    typedef struct packed {
        logic [1:0]                   mode;
        logic [ELAPSED_W-1:0]         elapsed_ms;
        logic [EDGE_W-1:0]            edge_count;
        logic [1:0][TIME_W-1:0]       alarm_times;
        logic [1:0]                   alarm_set;
        logic [1:0]                   alarm_done;
    } acmc_state_t;

    typedef struct packed {
        logic [1:0] motor_drive;
        logic [2:0] outcome;
        logic [1:0] alarm_fired;
    } acmc_result_t;

    typedef struct packed {
        logic [TIMEOUT_W-1:0] move_timeout_ms;
        logic [EDGE_W-1:0]    stall_edge_limit;
    } acmc_cfg_t;

endpackage

`default_nettype wire

// ===== design/acmc_step.sv =====
// Combinational state update of the controller for one input word.
// Depends on acmc_pkg.
`default_nettype none

module acmc_step
    import acmc_pkg::*;
(
    input  acmc_state_t  cur,
    input  acmc_cfg_t    cfg,
    input  acmc_item_t   item,
    output acmc_state_t  nxt,
    output acmc_result_t res
);

    logic [ELAPSED_W-1:0] elapsed_inc;
    logic                 timeout_hit;
    logic                 at_end;
    logic [1:0]           due;
    logic [EDGE_W-1:0]    edge_inc;
    logic                 moving;

    assign moving      = (cur.mode != MODE_IDLE);
    assign elapsed_inc = (cur.elapsed_ms != ELAPSED_MAX) ? cur.elapsed_ms + 1'b1
                                                         : cur.elapsed_ms;
    assign timeout_hit = elapsed_inc > {1'b0, cfg.move_timeout_ms};
    assign at_end      = (cur.mode == MODE_UP) ? item.ceiling_detected
                                               : item.floor_detected;
    assign due[0] = (item.time_of_day_ms >= cur.alarm_times[0]) && !cur.alarm_done[0];
    assign due[1] = (item.time_of_day_ms >= cur.alarm_times[1]) && !cur.alarm_done[1];
    assign edge_inc = cur.edge_count + 1'b1;

    always_comb
    begin
        nxt             = cur;
        res.outcome     = OUT_NONE;
        res.alarm_fired = FIRED_NONE;
        unique case (item.operation)
            OP_TICK:
            begin
                if (moving)
                begin
                    nxt.elapsed_ms = elapsed_inc;
                    if (timeout_hit)
                    begin
                        res.outcome = OUT_TIMEOUT;
                        nxt.mode    = MODE_IDLE;
                    end
                    else if (at_end)
                    begin
                        res.outcome = OUT_END;
                        nxt.mode    = MODE_IDLE;
                    end
                    else if (item.motor_halted)
                    begin
                        res.outcome = OUT_HALTED;
                        nxt.mode    = MODE_IDLE;
                    end
                end
                else
                begin
                    // The up alarm wins; the down alarm waits for a later tick.
                    if (due[0])
                    begin
                        nxt.alarm_done[0] = 1'b1;
                        if (cur.alarm_set[0])
                        begin
                            nxt.mode        = MODE_UP;
                            nxt.elapsed_ms  = '0;
                            nxt.edge_count  = '0;
                            res.alarm_fired = FIRED_UP;
                        end
                    end
                    if (due[1] && !(due[0] && cur.alarm_set[0]))
                    begin
                        nxt.alarm_done[1] = 1'b1;
                        if (cur.alarm_set[1])
                        begin
                            nxt.mode        = MODE_DOWN;
                            nxt.elapsed_ms  = '0;
                            nxt.edge_count  = '0;
                            res.alarm_fired = FIRED_DOWN;
                        end
                    end
                end
            end
            OP_MAN_UP, OP_MAN_DOWN:
            begin
                if (!moving)
                begin
                    nxt.mode       = (item.operation == OP_MAN_UP) ? MODE_UP : MODE_DOWN;
                    nxt.elapsed_ms = '0;
                    nxt.edge_count = '0;
                end
            end
            OP_SET_UP:
            begin
                nxt.alarm_times[0] = item.alarm_ms;
                nxt.alarm_set[0]   = 1'b1;
                nxt.alarm_done[0]  = item.time_of_day_ms > item.alarm_ms;
            end
            OP_SET_DOWN:
            begin
                nxt.alarm_times[1] = item.alarm_ms;
                nxt.alarm_set[1]   = 1'b1;
                nxt.alarm_done[1]  = item.time_of_day_ms > item.alarm_ms;
            end
            OP_MIDNIGHT:
            begin
                nxt.alarm_done = '0;
            end
            OP_CUR_EDGE:
            begin
                nxt.edge_count = edge_inc;
                if (edge_inc >= cfg.stall_edge_limit)
                begin
                    nxt.edge_count = '0;
                    if (moving)
                    begin
                        res.outcome = OUT_STALL;
                        nxt.mode    = MODE_IDLE;
                    end
                end
            end
            default:
            begin
                nxt = cur;
            end
        endcase
        res.motor_drive = nxt.mode;
    end

endmodule

`default_nettype wire

// ===== design/alarm_curtain_motor_controller.sv =====
// Top level of the alarm curtain motor controller: input stage, state, result stage.
// Depends on acmc_pkg and acmc_step.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------------------
//  in      | into      | in_valid / in_stall  | operation, time_of_day_ms, alarm_ms,
//          |           |                      | ceiling_detected, floor_detected,
//          |           |                      | motor_halted
//  out     | out of    | out_valid / out_stall| motor_drive, outcome, alarm_fired
//  cfg     | into      | cfg_write_en         | cfg_index, cfg_data
//
// Every input word yields exactly one result word, written to the result register as the
// word leaves the input register. One word per cycle while the output is not stalled:
// the state update is a single pass through acmc_step between the input register and
// the result register. Reset (rst_n low, asynchronous) clears the move state, alarms
// and flags, and sets the stall edge limit to 5 and the move timeout to its reset value.
// A full, stalled result register holds the input word and raises in_stall.
`default_nettype none

module alarm_curtain_motor_controller
    import acmc_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,

    input  wire logic                 in_valid,
    output logic                      in_stall,
    input  wire logic [2:0]           operation,
    input  wire logic [TIME_W-1:0]    time_of_day_ms,
    input  wire logic [TIME_W-1:0]    alarm_ms,
    input  wire logic                 ceiling_detected,
    input  wire logic                 floor_detected,
    input  wire logic                 motor_halted,

    output logic                      out_valid,
    input  wire logic                 out_stall,
    output logic [1:0]                motor_drive,
    output logic [2:0]                outcome,
    output logic [1:0]                alarm_fired,

    input  wire logic                 cfg_write_en,
    input  wire logic                 cfg_index,
    input  wire logic [TIMEOUT_W-1:0] cfg_data
);

    // Input stage: one word waiting to update the state.
    logic         in_vld_reg;
    acmc_item_t   item_reg;

    // Controller state and configuration registers.
    acmc_state_t  state_reg;
    acmc_state_t  state_next;
    acmc_cfg_t    cfg_reg;

    // Result stage.
    logic         out_vld_reg;
    acmc_result_t result_reg;
    acmc_result_t result_next;

    logic         advance;
    logic         in_take;

    // A word leaves the input stage when the result register is free or drains now.
    assign advance  = in_vld_reg && (!out_vld_reg || !out_stall);
    assign in_stall = in_vld_reg && !advance;
    assign in_take  = in_valid && !in_stall;

    acmc_step u_step (
        .cur  (state_reg),
        .cfg  (cfg_reg),
        .item (item_reg),
        .nxt  (state_next),
        .res  (result_next)
    );

    // Control, state and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg               <= 1'b0;
            out_vld_reg              <= 1'b0;
            state_reg                <= '0;
            cfg_reg.move_timeout_ms  <= TIMEOUT_RESET;
            cfg_reg.stall_edge_limit <= EDGE_LIMIT_RESET;
        end
        else
        begin
            if (in_take)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end

            if (advance)
            begin
                out_vld_reg <= 1'b1;
                state_reg   <= state_next;
            end
            else if (!out_stall)
            begin
                out_vld_reg <= 1'b0;
            end

            if (cfg_write_en)
            begin
                unique case (cfg_index)
                    CFG_MOVE_TIMEOUT: cfg_reg.move_timeout_ms  <= cfg_data;
                    CFG_EDGE_LIMIT:   cfg_reg.stall_edge_limit <= cfg_data[EDGE_W-1:0];
                    default:          cfg_reg                  <= cfg_reg;
                endcase
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.operation        <= operation;
            item_reg.time_of_day_ms   <= time_of_day_ms;
            item_reg.alarm_ms         <= alarm_ms;
            item_reg.ceiling_detected <= ceiling_detected;
            item_reg.floor_detected   <= floor_detected;
            item_reg.motor_halted     <= motor_halted;
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign out_valid   = out_vld_reg;
    assign motor_drive = result_reg.motor_drive;
    assign outcome     = result_reg.outcome;
    assign alarm_fired = result_reg.alarm_fired;

    // A move that ends leaves the motor stopped.
    a_outcome_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && outcome != OUT_NONE) |-> (motor_drive == MODE_IDLE))
        else $error("move ended but motor still driven");

    // An alarm start drives the motor in the alarm's direction and ends nothing.
    a_fired_drives: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && alarm_fired != FIRED_NONE) |->
            (outcome == OUT_NONE && motor_drive == alarm_fired))
        else $error("alarm start reports wrong drive or outcome");

    // A stalled result is never dropped by the pipeline.
    a_result_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> out_valid)
        else $error("stalled result lost");

    // A word in the input stage moves on whenever the result register is free.
    a_stage_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && !out_vld_reg) |=> out_vld_reg)
        else $error("input stage did not advance into free result register");

endmodule

`default_nettype wire
